### hdl/tsoi_pkg.sv
// tsoi_pkg: types, constants and helpers for the tcp syn option insert rewriter
// used by tsoi_accum, tsoi_finish and tcp_syn_option_insert_rewriter_core
// no dependencies
package tsoi_pkg;

  localparam int MAX_PACKET_BYTES = 65535;
  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

  localparam logic [7:0] IP_VER_IHL = 8'h45;
  localparam logic [7:0] PROTO_TCP = 8'h06;
  localparam logic [7:0] OPTION_KIND_RESET = 8'hfd;
  localparam logic [7:0] OPTION_LEN = 8'h08;
  localparam logic [7:0] TCP_SYN_MASK = 8'h02;
  localparam logic [15:0] DOFF_ADJ_WORD = 16'h2000;
  localparam logic [16:0] MAX_LEN_BEFORE_INSERT = 17'd65527;
  localparam logic [15:0] IP_HDR_BYTES = 16'd20;
  localparam logic [3:0] DOFF_MIN = 4'd5;
  localparam logic [3:0] DOFF_MAX = 4'd13;
  localparam logic [3:0] DOFF_GROWTH = 4'd2;

  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PACKET_BYTES);
  localparam logic [POS_W-1:0] POS_VER_IHL = POS_W'(0);
  localparam logic [POS_W-1:0] POS_TOT_LEN_LO = POS_W'(3);
  localparam logic [POS_W-1:0] POS_PROTO = POS_W'(9);
  localparam logic [POS_W-1:0] POS_IP_CSUM_LO = POS_W'(11);
  localparam logic [POS_W-1:0] POS_SEG_START = POS_W'(13);
  localparam logic [POS_W-1:0] POS_DST_FIRST = POS_W'(16);
  localparam logic [POS_W-1:0] POS_DST_LAST = POS_W'(19);
  localparam logic [POS_W-1:0] POS_TCP_START = POS_W'(20);
  localparam logic [POS_W-1:0] POS_PORT_HI = POS_W'(22);
  localparam logic [POS_W-1:0] POS_PORT_LO = POS_W'(23);
  localparam logic [POS_W-1:0] POS_DOFF = POS_W'(32);
  localparam logic [POS_W-1:0] POS_TCP_FLAGS = POS_W'(33);
  localparam logic [POS_W-1:0] POS_TCP_CSUM_HI = POS_W'(36);
  localparam logic [POS_W-1:0] POS_TCP_CSUM_LO = POS_W'(37);

  localparam int FLAG_VER = 0;
  localparam int FLAG_PROTO = 1;
  localparam int FLAG_SYN = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        rewrite;
    logic [6:0]  insert_offset;
    logic [3:0]  new_data_offset;
    logic [15:0] new_total_length;
    logic [15:0] new_ip_checksum;
    logic [15:0] new_tcp_checksum;
    logic [31:0] option_address;
    logic [15:0] option_port;
  } out_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             ovf;
    logic [2:0]       flags;
    logic [3:0]       doff;
    logic [15:0]      ip_sum;
    logic [15:0]      seg_sum;
    logic [31:0]      dst_addr;
    logic [15:0]      dst_port;
    logic [7:0]       kind;
  } snap_t;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

### hdl/tsoi_accum.sv
// tsoi_accum: per-byte header capture and running ones-complement sums,
// plus the end-of-packet snapshot register; depends on tsoi_pkg
module tsoi_accum (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tsoi_pkg::in_t       in_data,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  output logic                snap_valid,
  output tsoi_pkg::snap_t     snap,
  input  logic                snap_take
);

  logic [tsoi_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [15:0] ip_header_sum, ip_header_sum_next;
  logic [15:0] segment_sum, segment_sum_next;
  logic [2:0]  match_flags, match_flags_next;
  logic [3:0]  tcp_offset_words, tcp_offset_words_next;
  logic [31:0] destination_address, destination_address_next;
  logic [15:0] destination_port, destination_port_next;
  logic [7:0]  pending_high_byte, pending_high_byte_next;
  logic [7:0]  option_kind;
  logic        accept;
  logic        ovf;
  logic [7:0]  b;
  logic [tsoi_pkg::POS_W-1:0] pos;

  assign in_stall = snap_valid && !snap_take;
  assign accept = in_valid && !in_stall;
  assign b = in_data.data_byte;
  assign pos = byte_position;
  assign ovf = pos >= tsoi_pkg::MAX_POS;

  always_comb begin
    byte_position_next = byte_position;
    ip_header_sum_next = ip_header_sum;
    segment_sum_next = segment_sum;
    match_flags_next = match_flags;
    tcp_offset_words_next = tcp_offset_words;
    destination_address_next = destination_address;
    destination_port_next = destination_port;
    pending_high_byte_next = pending_high_byte;
    if (!ovf) begin
      if (pos == tsoi_pkg::POS_VER_IHL && b == tsoi_pkg::IP_VER_IHL) begin
        match_flags_next[tsoi_pkg::FLAG_VER] = 1'b1;
      end
      if (pos == tsoi_pkg::POS_PROTO && b == tsoi_pkg::PROTO_TCP) begin
        match_flags_next[tsoi_pkg::FLAG_PROTO] = 1'b1;
      end
      if (pos == tsoi_pkg::POS_TCP_FLAGS && (b & tsoi_pkg::TCP_SYN_MASK) != 8'h00) begin
        match_flags_next[tsoi_pkg::FLAG_SYN] = 1'b1;
      end
      if (pos == tsoi_pkg::POS_DOFF) begin
        tcp_offset_words_next = b[7:4];
      end
      if (pos >= tsoi_pkg::POS_DST_FIRST && pos <= tsoi_pkg::POS_DST_LAST) begin
        destination_address_next = {destination_address[23:0], b};
      end
      if (pos == tsoi_pkg::POS_PORT_HI || pos == tsoi_pkg::POS_PORT_LO) begin
        destination_port_next = {destination_port[7:0], b};
      end
      if (!pos[0]) begin
        pending_high_byte_next = b;
        if (in_data.last_byte && pos >= tsoi_pkg::POS_TCP_START &&
            pos != tsoi_pkg::POS_TCP_CSUM_HI) begin
          segment_sum_next = tsoi_pkg::ones_add(segment_sum, {b, 8'h00});
        end
      end else begin
        if (pos < tsoi_pkg::POS_TCP_START && pos != tsoi_pkg::POS_TOT_LEN_LO &&
            pos != tsoi_pkg::POS_IP_CSUM_LO) begin
          ip_header_sum_next = tsoi_pkg::ones_add(ip_header_sum, {pending_high_byte, b});
        end
        if (pos >= tsoi_pkg::POS_SEG_START && pos != tsoi_pkg::POS_TCP_CSUM_LO) begin
          segment_sum_next = tsoi_pkg::ones_add(segment_sum, {pending_high_byte, b});
        end
      end
      byte_position_next = pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      option_kind <= tsoi_pkg::OPTION_KIND_RESET;
    end else if (cfg_wr_en) begin
      option_kind <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      ip_header_sum <= '0;
      segment_sum <= '0;
      match_flags <= '0;
      tcp_offset_words <= '0;
      destination_address <= '0;
      destination_port <= '0;
      pending_high_byte <= '0;
    end else if (accept) begin
      if (in_data.last_byte) begin
        byte_position <= '0;
        ip_header_sum <= '0;
        segment_sum <= '0;
        match_flags <= '0;
        tcp_offset_words <= '0;
        destination_address <= '0;
        destination_port <= '0;
        pending_high_byte <= '0;
      end else begin
        byte_position <= byte_position_next;
        ip_header_sum <= ip_header_sum_next;
        segment_sum <= segment_sum_next;
        match_flags <= match_flags_next;
        tcp_offset_words <= tcp_offset_words_next;
        destination_address <= destination_address_next;
        destination_port <= destination_port_next;
        pending_high_byte <= pending_high_byte_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && in_data.last_byte) begin
      snap_valid <= 1'b1;
    end else if (snap_take) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last_byte) begin
      snap.pos <= pos;
      snap.ovf <= ovf;
      snap.flags <= match_flags_next;
      snap.doff <= tcp_offset_words_next;
      snap.ip_sum <= ip_header_sum_next;
      snap.seg_sum <= segment_sum_next;
      snap.dst_addr <= destination_address_next;
      snap.dst_port <= destination_port_next;
      snap.kind <= option_kind;
    end
  end

endmodule

### hdl/tsoi_finish.sv
// tsoi_finish: header checks, new lengths and checksum completion from a
// packet snapshot into the result register; depends on tsoi_pkg
module tsoi_finish (
  input  logic                clk,
  input  logic                rst,
  input  logic                snap_valid,
  input  tsoi_pkg::snap_t     snap,
  output logic                snap_take,
  output logic                out_valid,
  input  logic                out_stall,
  output tsoi_pkg::out_t      out_data
);

  logic        advance;
  logic [16:0] len;
  logic [6:0]  hdr;
  logic        ok;
  logic [15:0] total;
  logic [15:0] tcp_len;
  logic [31:0] opt_addr;
  logic [15:0] opt_port;
  logic [18:0] raw_sum;
  logic [16:0] fold1;
  logic [15:0] fold2;
  tsoi_pkg::out_t res;

  assign advance = !out_valid || !out_stall;
  assign snap_take = snap_valid && advance;

  always_comb begin
    len = {1'b0, snap.pos} + 17'd1;
    hdr = 7'(tsoi_pkg::IP_HDR_BYTES) + {1'b0, snap.doff, 2'b00};
    ok = !snap.ovf && snap.flags == 3'b111 &&
         snap.doff >= tsoi_pkg::DOFF_MIN && snap.doff <= tsoi_pkg::DOFF_MAX &&
         len >= {10'b0, hdr} && len <= tsoi_pkg::MAX_LEN_BEFORE_INSERT;
    total = 16'(len + 17'({tsoi_pkg::OPTION_LEN}));
    tcp_len = total - tsoi_pkg::IP_HDR_BYTES;
    opt_addr = {snap.dst_addr[7:0], snap.dst_addr[15:8],
                snap.dst_addr[23:16], snap.dst_addr[31:24]};
    opt_port = {snap.dst_port[7:0], snap.dst_port[15:8]};
    raw_sum = {3'b0, snap.seg_sum} + {3'b0, tsoi_pkg::DOFF_ADJ_WORD} +
              {3'b0, snap.kind, tsoi_pkg::OPTION_LEN} + {3'b0, opt_addr[31:16]} +
              {3'b0, opt_addr[15:0]} + {3'b0, opt_port} +
              {11'b0, tsoi_pkg::PROTO_TCP} + {3'b0, tcp_len};
    fold1 = {1'b0, raw_sum[15:0]} + {14'b0, raw_sum[18:16]};
    fold2 = fold1[15:0] + {15'b0, fold1[16]};
    res = '0;
    if (ok) begin
      res.rewrite = 1'b1;
      res.insert_offset = hdr;
      res.new_data_offset = snap.doff + tsoi_pkg::DOFF_GROWTH;
      res.new_total_length = total;
      res.new_ip_checksum = ~tsoi_pkg::ones_add(snap.ip_sum, total);
      res.new_tcp_checksum = ~fold2;
      res.option_address = opt_addr;
      res.option_port = opt_port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      out_data <= res;
    end
  end

endmodule

### hdl/tcp_syn_option_insert_rewriter_core.sv
// tcp_syn_option_insert_rewriter_core: top level, byte accumulator and finisher
// depends on tsoi_pkg, tsoi_accum, tsoi_finish
//
// Takes one IPv4 packet byte per cycle (a transaction on the in channel) and,
// for each byte marked last, delivers one result transaction that describes
// the 8-byte TCP option insertion for a SYN, or rewrite = 0 with all other
// fields zero. Bytes are accepted every cycle while the result side flows; the
// input stalls only while a snapshot waits behind a held result. The snapshot
// register loads at the edge that accepts the last byte and the result register
// loads from the snapshot at the first edge at which the result side can advance.
// cfg_wr_en writes option_kind, reset 0xfd.
module tcp_syn_option_insert_rewriter_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  tsoi_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output tsoi_pkg::out_t   out_data,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data
);

  logic            snap_valid;
  logic            snap_take;
  tsoi_pkg::snap_t snap;

  tsoi_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_take  (snap_take)
  );

  tsoi_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .snap_valid(snap_valid),
    .snap      (snap),
    .snap_take (snap_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> snap_valid)
    else $error("input stalled with empty snapshot stage");

  a_pass_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.rewrite |->
      out_data.insert_offset == 7'd0 && out_data.new_total_length == 16'd0 &&
      out_data.new_tcp_checksum == 16'd0)
    else $error("nonzero fields on a pass-through result");

  a_offset_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.rewrite |->
      {1'b0, out_data.new_data_offset, 2'b00} + 7'd12 == out_data.insert_offset)
    else $error("insert offset and new data offset disagree");

  a_length_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.rewrite |-> out_data.new_total_length >= 16'd48)
    else $error("rewritten packet shorter than minimum header");
`endif

endmodule

### dv/tb_top.sv
// tb_top: self-checking testbench for tcp_syn_option_insert_rewriter_core
// streams ipv4 packets byte by byte and checks each option-insert edit against a local model
// depends on tsoi_pkg and tcp_syn_option_insert_rewriter_core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_REPORTS   = 10;

  typedef enum int {
    PKT_GOOD,
    PKT_BAD_VER,
    PKT_BAD_PROTO,
    PKT_NO_SYN,
    PKT_BAD_DOFF,
    PKT_SHORT,
    PKT_NOISE,
    PKT_ZEROS,
    PKT_ONES
  } pkt_kind_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  tsoi_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  tsoi_pkg::out_t out_data;
  logic           cfg_wr_en = 1'b0;
  logic [7:0]     cfg_wr_data = '0;

  tsoi_pkg::in_t  pending_bytes[$];
  tsoi_pkg::out_t expected_edits[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_active = 1'b0;
  int hold_cnt = 0;
  int fail_count = 0;

  // model state of the packet in progress
  int unsigned pkt_pos = 0;
  logic [31:0] ip_sum = '0;
  logic [31:0] seg_sum = '0;
  logic [2:0]  pkt_flags = '0;
  logic [3:0]  pkt_doff = '0;
  logic [31:0] dst_addr = '0;
  logic [15:0] dst_port = '0;
  logic [7:0]  high_byte = '0;
  logic [7:0]  kind_reg = tsoi_pkg::OPTION_KIND_RESET;

  tcp_syn_option_insert_rewriter_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] ones_fold(input logic [31:0] s);
    logic [31:0] v;
    v = s;
    while (v[31:16] != 0) v = {16'h0, v[15:0]} + {16'h0, v[31:16]};
    return v;
  endfunction

  task automatic predict_edit(input tsoi_pkg::in_t t);
    logic [7:0]     b;
    logic           ovf;
    int unsigned    pos;
    int unsigned    len;
    int unsigned    hdr;
    logic [16:0]    total;
    logic [31:0]    oa;
    logic [15:0]    op;
    logic [31:0]    s;
    logic [31:0]    ipc;
    tsoi_pkg::out_t r;
    b = t.data_byte;
    pos = pkt_pos;
    ovf = pos >= tsoi_pkg::MAX_PACKET_BYTES;
    if (!ovf) begin
      if (pos == tsoi_pkg::POS_VER_IHL && b == tsoi_pkg::IP_VER_IHL)
        pkt_flags[tsoi_pkg::FLAG_VER] = 1'b1;
      if (pos == tsoi_pkg::POS_PROTO && b == tsoi_pkg::PROTO_TCP)
        pkt_flags[tsoi_pkg::FLAG_PROTO] = 1'b1;
      if (pos == tsoi_pkg::POS_TCP_FLAGS && (b & tsoi_pkg::TCP_SYN_MASK) != 0)
        pkt_flags[tsoi_pkg::FLAG_SYN] = 1'b1;
      if (pos == tsoi_pkg::POS_DOFF) pkt_doff = b[7:4];
      if (pos >= tsoi_pkg::POS_DST_FIRST && pos <= tsoi_pkg::POS_DST_LAST)
        dst_addr = {dst_addr[23:0], b};
      if (pos == tsoi_pkg::POS_PORT_HI || pos == tsoi_pkg::POS_PORT_LO)
        dst_port = {dst_port[7:0], b};
      if (pos[0] == 1'b0) begin
        high_byte = b;
        // odd tail byte padded as a high byte
        if (t.last_byte && pos >= tsoi_pkg::POS_TCP_START &&
            pos != tsoi_pkg::POS_TCP_CSUM_HI)
          seg_sum = ones_fold(seg_sum + {16'h0, b, 8'h00});
      end else begin
        if (pos < tsoi_pkg::POS_TCP_START && pos != tsoi_pkg::POS_TOT_LEN_LO &&
            pos != tsoi_pkg::POS_IP_CSUM_LO)
          ip_sum = ones_fold(ip_sum + {16'h0, high_byte, b});
        if (pos >= tsoi_pkg::POS_SEG_START && pos != tsoi_pkg::POS_TCP_CSUM_LO)
          seg_sum = ones_fold(seg_sum + {16'h0, high_byte, b});
      end
      pkt_pos = pos + 1;
    end
    if (t.last_byte) begin
      r = '0;
      len = pos + 1;
      hdr = 20 + 4 * pkt_doff;
      if (!ovf && pkt_flags == 3'b111 && pkt_doff >= tsoi_pkg::DOFF_MIN &&
          pkt_doff <= tsoi_pkg::DOFF_MAX && len >= hdr &&
          len <= tsoi_pkg::MAX_LEN_BEFORE_INSERT) begin
        total = 17'(len + 8);
        oa = {dst_addr[7:0], dst_addr[15:8], dst_addr[23:16], dst_addr[31:24]};
        op = {dst_port[7:0], dst_port[15:8]};
        s = ones_fold(seg_sum + {16'h0, tsoi_pkg::DOFF_ADJ_WORD});
        s = ones_fold(s + {16'h0, kind_reg, tsoi_pkg::OPTION_LEN});
        s = ones_fold(s + {16'h0, oa[31:16]});
        s = ones_fold(s + {16'h0, oa[15:0]});
        s = ones_fold(s + {16'h0, op});
        s = ones_fold(s + {24'h0, tsoi_pkg::PROTO_TCP});
        s = ones_fold(s + {15'h0, total} - 32'd20);
        ipc = ones_fold(ip_sum + {15'h0, total});
        r.rewrite = 1'b1;
        r.insert_offset = 7'(hdr);
        r.new_data_offset = pkt_doff + tsoi_pkg::DOFF_GROWTH;
        r.new_total_length = total[15:0];
        r.new_ip_checksum = ~ipc[15:0];
        r.new_tcp_checksum = ~s[15:0];
        r.option_address = oa;
        r.option_port = op;
      end
      expected_edits.push_back(r);
      pkt_pos = 0;
      ip_sum = '0;
      seg_sum = '0;
      pkt_flags = '0;
      pkt_doff = '0;
      dst_addr = '0;
      dst_port = '0;
      high_byte = '0;
    end
  endtask

  task automatic queue_packet(input pkt_kind_t k, input int doff, input int len);
    logic [7:0]    b;
    tsoi_pkg::in_t t;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (k == PKT_ZEROS) b = 8'h00;
      if (k == PKT_ONES) b = 8'hff;
      if (k != PKT_NOISE && k != PKT_ZEROS && k != PKT_ONES) begin
        if (i == tsoi_pkg::POS_VER_IHL) begin
          if (k != PKT_BAD_VER) b = tsoi_pkg::IP_VER_IHL;
          else if (b == tsoi_pkg::IP_VER_IHL) b = 8'h46;
        end
        if (i == tsoi_pkg::POS_PROTO) begin
          if (k != PKT_BAD_PROTO) b = tsoi_pkg::PROTO_TCP;
          else if (b == tsoi_pkg::PROTO_TCP) b = 8'h11;
        end
        if (i == tsoi_pkg::POS_DOFF) b = {4'(doff), b[3:0]};
        if (i == tsoi_pkg::POS_TCP_FLAGS)
          b = (k == PKT_NO_SYN) ? (b & ~tsoi_pkg::TCP_SYN_MASK) :
                                  (b | tsoi_pkg::TCP_SYN_MASK);
      end
      t.data_byte = b;
      t.last_byte = (i == len - 1);
      pending_bytes.push_back(t);
    end
  endtask

  task automatic queue_random(input int byte_goal, input int pkt_goal);
    int nbytes;
    int npkts;
    int sel;
    int doff;
    int len;
    pkt_kind_t k;
    nbytes = 0;
    npkts = 0;
    while (nbytes < byte_goal || npkts < pkt_goal) begin
      sel = $urandom_range(99, 0);
      if (sel < 65) k = PKT_GOOD;
      else if (sel < 70) k = PKT_BAD_VER;
      else if (sel < 75) k = PKT_BAD_PROTO;
      else if (sel < 80) k = PKT_NO_SYN;
      else if (sel < 85) k = PKT_BAD_DOFF;
      else if (sel < 90) k = PKT_SHORT;
      else k = PKT_NOISE;
      doff = ($urandom_range(9, 0) < 7) ? $urandom_range(7, 5) : $urandom_range(13, 5);
      len = 20 + 4 * doff + $urandom_range(24, 0);
      if (k == PKT_BAD_DOFF) begin
        doff = $urandom_range(6, 0);
        if (doff > 4) doff = doff + 9;
        len = 34 + $urandom_range(60, 0);
      end
      if (k == PKT_SHORT) len = $urandom_range(20 + 4 * doff - 1, 1);
      if (k == PKT_NOISE) len = $urandom_range(12, 1);
      queue_packet(k, doff, len);
      nbytes += len;
      npkts++;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_edits.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_kind(input logic [7:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    kind_reg <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_edit(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    tsoi_pkg::out_t want;
    logic bad;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_edits.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("unexpected result transaction: %h", out_data);
          fail_count++;
        end else begin
          want = expected_edits.pop_front();
          bad = out_data.rewrite !== want.rewrite ||
                out_data.insert_offset !== want.insert_offset ||
                out_data.new_data_offset !== want.new_data_offset ||
                out_data.new_total_length !== want.new_total_length ||
                out_data.new_ip_checksum !== want.new_ip_checksum ||
                out_data.new_tcp_checksum !== want.new_tcp_checksum ||
                out_data.option_address !== want.option_address ||
                out_data.option_port !== want.option_port;
          if (bad) begin
            if (fail_count < MAX_REPORTS) begin
              $display("mismatch exp: rw=%0d off=%0d doff=%0d len=%0d ipc=%h tcpc=%h a=%h p=%h",
                       want.rewrite, want.insert_offset, want.new_data_offset,
                       want.new_total_length, want.new_ip_checksum, want.new_tcp_checksum,
                       want.option_address, want.option_port);
              $display("         got: rw=%0d off=%0d doff=%0d len=%0d ipc=%h tcpc=%h a=%h p=%h",
                       out_data.rewrite, out_data.insert_offset, out_data.new_data_offset,
                       out_data.new_total_length, out_data.new_ip_checksum,
                       out_data.new_tcp_checksum, out_data.option_address,
                       out_data.option_port);
            end
            fail_count++;
          end
        end
      end
      out_stall <= hold_active || ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_active) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_CYCLES - 1) hold_active <= 1'b0;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed packets, reset kind
    queue_packet(PKT_GOOD, 5, 40);
    queue_packet(PKT_GOOD, 5, 41);
    queue_packet(PKT_GOOD, 13, 72);
    queue_packet(PKT_BAD_DOFF, 4, 36);
    queue_packet(PKT_BAD_DOFF, 14, 36);
    queue_packet(PKT_BAD_VER, 5, 40);
    queue_packet(PKT_BAD_PROTO, 5, 40);
    queue_packet(PKT_NO_SYN, 5, 40);
    queue_packet(PKT_NOISE, 0, 1);
    queue_packet(PKT_NOISE, 0, 2);
    queue_packet(PKT_ZEROS, 0, 34);
    queue_packet(PKT_ONES, 0, 34);
    wait_drained();

    write_kind(8'h00);
    send_idle_pct = 85;
    recv_stall_pct = 0;
    queue_random(110, 2);
    wait_drained();

    write_kind(8'hff);
    send_idle_pct = 0;
    recv_stall_pct = 85;
    queue_random(110, 2);
    wait_drained();

    write_kind(8'($urandom));
    send_idle_pct = 36;
    recv_stall_pct = 36;
    queue_random(110, 2);
    wait_drained();

    // receiver held off while the sender keeps offering short packets
    write_kind(tsoi_pkg::OPTION_KIND_RESET);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cnt = 0;
    hold_active = 1'b1;
    for (int i = 0; i < 30; i++) queue_packet(PKT_NOISE, 0, $urandom_range(3, 1));
    queue_random(40, 1);
    wait_drained();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
